FILE: hdl/nacp_pkg.sv
// ============================================================================
// nacp_pkg: shared types and constants for the admin completion poster
// Holds opcode and feature codes, the decoded command word, and queue sizing.
// ============================================================================
package nacp_pkg;

    localparam int QUEUE_DEPTH_MAX = 4096;
    localparam int TAIL_W          = $clog2(QUEUE_DEPTH_MAX);
    localparam int SIZE_W          = 13;
    localparam int SQ_INDEX_W      = 12;
    localparam int QSIZE_W         = 17;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_SLOTS     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_SLOTS);
    localparam int QCNT_W          = $clog2(QUEUE_SLOTS + 1);

    localparam logic [7:0] OPC_CREATE_SQ = 8'h01;
    localparam logic [7:0] OPC_CREATE_CQ = 8'h05;
    localparam logic [7:0] OPC_SET_FEAT  = 8'h09;
    localparam logic [7:0] OPC_GET_FEAT  = 8'h0A;
    localparam logic [7:0] OPC_ASYNC_EVT = 8'h0C;

    localparam logic [7:0]  FID_WCACHE   = 8'h06;
    localparam logic [7:0]  FID_NQUEUES  = 8'h07;
    localparam logic [15:0] IO_QUEUE_ID  = 16'h0001;
    localparam logic [31:0] VECTOR_OFF   = 32'hFFFF_FFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_CQ_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQ_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CQ_SIZE = 2'd2;

    typedef enum logic [3:0] {
        OP_OTHER,
        OP_ASYNC,
        OP_CREATE_SQ1,
        OP_CREATE_CQ1,
        OP_SET_WCACHE,
        OP_SET_NQUEUES,
        OP_GET_WCACHE,
        OP_GET_NQUEUES,
        OP_FEAT_ECHO
    } nacp_op_t;

    typedef struct packed {
        nacp_op_t            op;
        logic [15:0]         cid;
        logic [31:0]         echo;
        logic [31:0]         value;
        logic [15:0]         sq_head;
        logic [63:0]         base;
        logic [QSIZE_W-1:0]  qsize;
        logic [31:0]         vector;
    } nacp_cmd_t;

endpackage

FILE: hdl/nvme_admin_completion_poster.sv
// ============================================================================
// nvme_admin_completion_poster: admin command completion builder
// Turns fetched admin commands into completion queue entries and tracks the
// features and I/O queue 1 settings that admin commands leave behind.
// ============================================================================
// Usage:
//   Command channel (cmd_valid / cmd_stall) carries one admin command word:
//   SQ slot, dword 0, PRP1, cdw10 and cdw11. Result channel (cpl_valid /
//   cpl_stall) returns one word per command: post_valid, the CQ slot address,
//   entry dwords 0, 2 and 3, and the I/O queue 1 settings after the command.
//   An async event request returns a word with post_valid low and a zero entry.
//   Configuration (cfg_we / cfg_index / cfg_data) sets the CQ base and the
//   admin SQ and CQ sizes; write it only while no command is in flight.
//
//   Path: the accept edge writes the command into the decode-side queue; the
//   execute stage then takes it from the queue and loads the output register.
//   Throughput is one command per cycle while the receiver does not stall,
//   set by the execute stage (tail add and feature-state update) and the
//   two-slot queue.
//
//   Reset empties the queue and the output register, sets the phase tag to 1,
//   the CQ tail and all feature and I/O queue state to 0, the CQ base to 0 and
//   both queue sizes to 1. When the receiver stalls, the result word holds,
//   the queue fills, and cmd_stall rises once both queue slots are taken.
// ============================================================================
module nvme_admin_completion_poster
    import nacp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  logic [SQ_INDEX_W-1:0]  sq_index,
    input  logic [31:0]            command_dw0,
    input  logic [63:0]            prp_entry1,
    input  logic [31:0]            cdw10,
    input  logic [31:0]            cdw11,

    output logic                   cpl_valid,
    input  logic                   cpl_stall,
    output logic                   post_valid,
    output logic [63:0]            entry_addr,
    output logic [31:0]            entry_dw0,
    output logic [15:0]            entry_dw2,
    output logic [16:0]            entry_dw3,
    output logic [63:0]            io_sq_base,
    output logic [16:0]            io_sq_entries,
    output logic [63:0]            io_cq_base,
    output logic [16:0]            io_cq_entries,
    output logic [31:0]            io_cq_vector
);

    // Configuration registers
    logic [63:0]       cq_base_reg;
    logic [SIZE_W-1:0] sq_size_reg;
    logic [SIZE_W-1:0] cq_size_reg;

    // Front to queue, queue to back
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;
    nacp_cmd_t push_cmd;
    nacp_cmd_t pop_cmd;

    // Register writes land on the cycle of the strobe; indexes past the list drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cq_base_reg <= '0;
            sq_size_reg <= SIZE_W'(1);
            cq_size_reg <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CQ_BASE: cq_base_reg <= cfg_data;
                CFG_SQ_SIZE: sq_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_CQ_SIZE: cq_size_reg <= cfg_data[SIZE_W-1:0];
                default:     cq_base_reg <= cq_base_reg;
            endcase
        end
    end

    // Classify the command and compute its SQ head and create-queue fields.
    nacp_front u_front (
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .sq_index    (sq_index),
        .command_dw0 (command_dw0),
        .prp_entry1  (prp_entry1),
        .cdw10       (cdw10),
        .cdw11       (cdw11),
        .sq_size     (sq_size_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Hold decoded commands while the result side stalls.
    nacp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // Apply state updates in order, advance the CQ tail, register the word.
    nacp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cq_base       (cq_base_reg),
        .cq_size       (cq_size_reg),
        .q_not_empty   (q_not_empty),
        .cmd           (pop_cmd),
        .pop           (pop),
        .cpl_valid     (cpl_valid),
        .cpl_stall     (cpl_stall),
        .post_valid    (post_valid),
        .entry_addr    (entry_addr),
        .entry_dw0     (entry_dw0),
        .entry_dw2     (entry_dw2),
        .entry_dw3     (entry_dw3),
        .io_sq_base    (io_sq_base),
        .io_sq_entries (io_sq_entries),
        .io_cq_base    (io_cq_base),
        .io_cq_entries (io_cq_entries),
        .io_cq_vector  (io_cq_vector)
    );

endmodule

FILE: hdl/nacp_front.sv
// ============================================================================
// nacp_front: command intake and classification
// Accepts a command word, sorts it into an operation class and works out
// the values that need no queue state (SQ head, queue size, vector).
// ============================================================================
module nacp_front
    import nacp_pkg::*;
(
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic [SQ_INDEX_W-1:0] sq_index,
    input  logic [31:0]           command_dw0,
    input  logic [63:0]           prp_entry1,
    input  logic [31:0]           cdw10,
    input  logic [31:0]           cdw11,
    input  logic [SIZE_W-1:0]     sq_size,
    input  logic                  q_full,
    output logic                  push,
    output nacp_cmd_t             push_cmd
);

    logic [7:0]        opc;
    logic [7:0]        fid;
    logic              for_q1;
    logic [SIZE_W-1:0] head_inc;
    logic              head_wrap;
    nacp_op_t          op;

    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    assign opc    = command_dw0[7:0];
    assign fid    = cdw10[7:0];
    assign for_q1 = (cdw10[15:0] == IO_QUEUE_ID);

    assign head_inc  = SIZE_W'(sq_index) + SIZE_W'(1);
    assign head_wrap = (head_inc >= sq_size) || (head_inc >= SIZE_W'(QUEUE_DEPTH_MAX));

    always_comb
    begin
        op = OP_OTHER;
        unique case (opc)
            OPC_ASYNC_EVT: op = OP_ASYNC;
            OPC_CREATE_SQ: op = for_q1 ? OP_CREATE_SQ1 : OP_OTHER;
            OPC_CREATE_CQ: op = for_q1 ? OP_CREATE_CQ1 : OP_OTHER;
            OPC_SET_FEAT:
            begin
                priority if (fid == FID_WCACHE)  op = OP_SET_WCACHE;
                else if (fid == FID_NQUEUES)     op = OP_SET_NQUEUES;
                else                             op = OP_FEAT_ECHO;
            end
            OPC_GET_FEAT:
            begin
                priority if (fid == FID_WCACHE)  op = OP_GET_WCACHE;
                else if (fid == FID_NQUEUES)     op = OP_GET_NQUEUES;
                else                             op = OP_FEAT_ECHO;
            end
            default: op = OP_OTHER;
        endcase
    end

    always_comb
    begin
        push_cmd.op      = op;
        push_cmd.cid     = command_dw0[31:16];
        push_cmd.echo    = command_dw0;
        push_cmd.value   = cdw11;
        push_cmd.sq_head = head_wrap ? 16'd0 : 16'(head_inc);
        push_cmd.base    = prp_entry1;
        push_cmd.qsize   = QSIZE_W'(cdw10[31:16]) + QSIZE_W'(1);
        push_cmd.vector  = cdw11[1] ? 32'(cdw11[31:16]) : VECTOR_OFF;
    end

endmodule

FILE: hdl/nacp_queue.sv
// ============================================================================
// nacp_queue: short command queue between intake and execution
// Two-slot FIFO; lets the intake keep accepting while the result side stalls.
// ============================================================================
module nacp_queue
    import nacp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  nacp_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output nacp_cmd_t pop_cmd
);

    nacp_cmd_t         slot_reg [QUEUE_SLOTS];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_SLOTS));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_SLOTS))
        else $error("queue count beyond slot count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

FILE: hdl/nacp_back.sv
// ============================================================================
// nacp_back: command execution and completion output register
// Applies each queued command to the feature and I/O queue state, builds the
// completion entry, advances the CQ tail and phase, and holds the result.
// ============================================================================
module nacp_back
    import nacp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [63:0]       cq_base,
    input  logic [SIZE_W-1:0] cq_size,
    input  logic              q_not_empty,
    input  nacp_cmd_t         cmd,
    output logic              pop,
    output logic              cpl_valid,
    input  logic              cpl_stall,
    output logic              post_valid,
    output logic [63:0]       entry_addr,
    output logic [31:0]       entry_dw0,
    output logic [15:0]       entry_dw2,
    output logic [16:0]       entry_dw3,
    output logic [63:0]       io_sq_base,
    output logic [16:0]       io_sq_entries,
    output logic [63:0]       io_cq_base,
    output logic [16:0]       io_cq_entries,
    output logic [31:0]       io_cq_vector
);

    logic                take;
    logic                posting;
    logic [SIZE_W-1:0]   tail_inc;
    logic                tail_wrap;
    logic [31:0]         result;

    logic [TAIL_W-1:0]   tail_reg;
    logic [TAIL_W-1:0]   tail_next;
    logic                phase_reg;
    logic                phase_next;
    logic                wce_reg;
    logic                wce_next;
    logic [31:0]         qcount_reg;
    logic [31:0]         qcount_next;
    logic [63:0]         sq_base_reg;
    logic [63:0]         sq_base_next;
    logic [QSIZE_W-1:0]  sq_qsize_reg;
    logic [QSIZE_W-1:0]  sq_qsize_next;
    logic [63:0]         cq_base_io_reg;
    logic [63:0]         cq_base_io_next;
    logic [QSIZE_W-1:0]  cq_qsize_reg;
    logic [QSIZE_W-1:0]  cq_qsize_next;
    logic [31:0]         vector_reg;
    logic [31:0]         vector_next;

    logic                out_valid_reg;
    logic                post_valid_reg;
    logic [63:0]         entry_addr_reg;
    logic [31:0]         entry_dw0_reg;
    logic [15:0]         entry_dw2_reg;
    logic [16:0]         entry_dw3_reg;

    // Take the next queued command whenever the output register is free or drains.
    assign take    = q_not_empty && (!out_valid_reg || !cpl_stall);
    assign pop     = take;
    assign posting = (cmd.op != OP_ASYNC);

    assign tail_inc  = SIZE_W'(tail_reg) + SIZE_W'(1);
    assign tail_wrap = (tail_inc >= cq_size) || (tail_inc >= SIZE_W'(QUEUE_DEPTH_MAX));

    always_comb
    begin
        wce_next        = wce_reg;
        qcount_next     = qcount_reg;
        sq_base_next    = sq_base_reg;
        sq_qsize_next   = sq_qsize_reg;
        cq_base_io_next = cq_base_io_reg;
        cq_qsize_next   = cq_qsize_reg;
        vector_next     = vector_reg;
        tail_next       = tail_reg;
        phase_next      = phase_reg;
        result          = '0;

        unique case (cmd.op)
            OP_CREATE_SQ1:
            begin
                sq_base_next  = cmd.base;
                sq_qsize_next = cmd.qsize;
            end
            OP_CREATE_CQ1:
            begin
                cq_base_io_next = cmd.base;
                cq_qsize_next   = cmd.qsize;
                vector_next     = cmd.vector;
            end
            OP_SET_WCACHE:  wce_next = cmd.value[0];
            OP_SET_NQUEUES:
            begin
                qcount_next = cmd.value;
                result      = cmd.value;
            end
            OP_GET_WCACHE:  result = 32'(wce_reg);
            OP_GET_NQUEUES: result = qcount_reg;
            OP_FEAT_ECHO:   result = cmd.echo;
            default:        result = '0;
        endcase

        if (posting)
        begin
            tail_next  = tail_wrap ? '0 : tail_inc[TAIL_W-1:0];
            phase_next = phase_reg ^ tail_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg       <= '0;
            phase_reg      <= 1'b1;
            wce_reg        <= 1'b0;
            qcount_reg     <= '0;
            sq_base_reg    <= '0;
            sq_qsize_reg   <= '0;
            cq_base_io_reg <= '0;
            cq_qsize_reg   <= '0;
            vector_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                tail_reg       <= tail_next;
                phase_reg      <= phase_next;
                wce_reg        <= wce_next;
                qcount_reg     <= qcount_next;
                sq_base_reg    <= sq_base_next;
                sq_qsize_reg   <= sq_qsize_next;
                cq_base_io_reg <= cq_base_io_next;
                cq_qsize_reg   <= cq_qsize_next;
                vector_reg     <= vector_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!cpl_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Completion payload; async events carry an all-zero entry.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            post_valid_reg <= posting;
            entry_addr_reg <= posting ? cq_base + (64'(tail_reg) << 4) : '0;
            entry_dw0_reg  <= posting ? result : '0;
            entry_dw2_reg  <= posting ? cmd.sq_head : '0;
            entry_dw3_reg  <= posting ? {phase_reg, cmd.cid} : '0;
        end
    end

    assign cpl_valid     = out_valid_reg;
    assign post_valid    = post_valid_reg;
    assign entry_addr    = entry_addr_reg;
    assign entry_dw0     = entry_dw0_reg;
    assign entry_dw2     = entry_dw2_reg;
    assign entry_dw3     = entry_dw3_reg;
    assign io_sq_base    = sq_base_reg;
    assign io_sq_entries = sq_qsize_reg;
    assign io_cq_base    = cq_base_io_reg;
    assign io_cq_entries = cq_qsize_reg;
    assign io_cq_vector  = vector_reg;

    a_async_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        take && !posting |=> $stable(tail_reg) && $stable(phase_reg))
        else $error("async event moved the CQ tail or phase");

    a_wrap_flips_phase: assert property (@(posedge clk) disable iff (!rst_n)
        take && posting && tail_wrap |=> tail_reg == '0 && phase_reg != $past(phase_reg))
        else $error("CQ wrap did not clear tail and flip phase");

    a_async_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !post_valid_reg |-> entry_dw3_reg == '0 && entry_addr_reg == '0)
        else $error("async event carries a nonzero entry");

endmodule
